// File: design/mbps_pkg.sv
package mbps_pkg;

   localparam int PATTERN_BYTES_DEFAULT = 16;
   localparam int MAX_PATTERN = 16;
   localparam int LEN_W = 5;
   localparam int PICK_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_EMPTY     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_SCAN_BASE      = 3'd0,
      REG_PATTERN_LOW    = 3'd1,
      REG_PATTERN_HIGH   = 3'd2,
      REG_WILDCARD_MASK  = 3'd3,
      REG_PATTERN_LENGTH = 3'd4,
      REG_MATCH_ORDINAL  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [31:0]      scan_base;
      logic [63:0]      pattern_low;
      logic [63:0]      pattern_high;
      logic [15:0]      wildcard_mask;
      logic [LEN_W-1:0] pattern_length;
      logic [31:0]      match_ordinal;
   } cfg_type;

   function automatic logic [7:0] pattern_byte(input cfg_type cfg,
                                               input logic [PICK_W-1:0] k);
      logic [127:0] pat;
      pat = {cfg.pattern_high, cfg.pattern_low};
      return pat[k * 8 +: 8];
   endfunction

endpackage

// File: design/mbps_if.sv
interface mbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_rsp_if;
   logic                 valid;
   logic                 ready;
   mbps_pkg::status_type status;
   logic [31:0]          match_address;

   modport source (output valid, output status, output match_address, input ready);
   modport sink (input valid, input status, input match_address, output ready);
endinterface

// File: design/mbps_csr.sv
module mbps_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mbps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mbps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mbps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output mbps_pkg::cfg_type               cfg
);
   import mbps_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_SCAN_BASE:      cfg_in.scan_base      = csr_pwdata[31:0];
            REG_PATTERN_LOW:    cfg_in.pattern_low    = csr_pwdata;
            REG_PATTERN_HIGH:   cfg_in.pattern_high   = csr_pwdata;
            REG_WILDCARD_MASK:  cfg_in.wildcard_mask  = csr_pwdata[15:0];
            REG_PATTERN_LENGTH: cfg_in.pattern_length = csr_pwdata[LEN_W-1:0];
            REG_MATCH_ORDINAL:  cfg_in.match_ordinal  = csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SCAN_BASE:      csr_prdata = {32'd0, cfg_ff.scan_base};
         REG_PATTERN_LOW:    csr_prdata = cfg_ff.pattern_low;
         REG_PATTERN_HIGH:   csr_prdata = cfg_ff.pattern_high;
         REG_WILDCARD_MASK:  csr_prdata = {48'd0, cfg_ff.wildcard_mask};
         REG_PATTERN_LENGTH: csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, cfg_ff.pattern_length};
         REG_MATCH_ORDINAL:  csr_prdata = {32'd0, cfg_ff.match_ordinal};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff               <= '0;
         cfg_ff.match_ordinal <= 32'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/mbps_cell.sv
module mbps_cell #(
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  logic                       shift_en,
   input  logic [7:0]                 shift_byte,
   output logic [7:0]                 window_byte,
   input  mbps_pkg::cfg_type          cfg,
   input  logic [mbps_pkg::LEN_W-1:0] eff_len,
   output logic                       hit
);
   import mbps_pkg::*;

   logic [7:0]        window_ff;
   logic [7:0]        window_in;
   logic              in_use;
   logic [LEN_W-1:0]  slot;
   logic [PICK_W-1:0] pick;

   // newest byte sits in cell 0; cell j faces pattern byte len-1-j
   assign in_use = LEN_W'(INDEX) < eff_len;
   assign slot   = eff_len - LEN_W'(INDEX) - LEN_W'(1);
   assign pick   = slot[PICK_W-1:0];
   assign hit    = !in_use || cfg.wildcard_mask[pick] || (shift_byte == pattern_byte(cfg, pick));

   assign window_in   = shift_en ? shift_byte : window_ff;
   assign window_byte = window_ff;

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

// File: design/masked_byte_pattern_scan_unit.sv
// Scans a byte stream, one word per cycle, for a pattern of up to 16 bytes with
// per-byte wildcards held in the CSRs. Bytes shift through a row of cells, each
// comparing its byte against the pattern byte it faces, so a complete match is
// known in the cycle its last byte is accepted. The Nth match (match_ordinal,
// zero acts as one) is reported as scan_base plus its start offset, after which
// the rest of the region is dropped without results. A region that ends without
// that match reports not found, or empty pattern when pattern_length is zero.
// Every word with last_byte set ends the region. Throughput is one byte per
// cycle; the result is registered in the output register and shows in the cycle
// after the deciding byte. Req ready drops only while that register is full and
// rsp stalls. CSRs must be written while the stream is idle; the unit won't check.
module masked_byte_pattern_scan_unit #(
   parameter int PATTERN_BYTES = mbps_pkg::PATTERN_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   mbps_req_if.sink                        req_word,
   mbps_rsp_if.source                      rsp_word,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mbps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mbps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mbps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import mbps_pkg::*;

   localparam int LANES = (PATTERN_BYTES < MAX_PATTERN) ? PATTERN_BYTES : MAX_PATTERN;

   cfg_type          cfg;
   logic [LEN_W-1:0] eff_len;
   logic [31:0]      want;
   logic [LANES-1:0] hits;
   logic [7:0]       chain [LANES+1];

   logic        accept;
   logic        shift_en;
   logic        full_hit;
   logic        found;
   logic [31:0] pos_next;
   logic [31:0] count_next;

   logic [31:0] pos_ff, pos_in;
   logic [31:0] count_ff, count_in;
   logic        finished_ff, finished_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_address_ff, rsp_address_in;

   mbps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign eff_len = (cfg.pattern_length > LEN_W'(LANES)) ? LEN_W'(LANES) : cfg.pattern_length;
   assign want    = (cfg.match_ordinal == 32'd0) ? 32'd1 : cfg.match_ordinal;

   assign req_word.ready = !rsp_valid_ff || rsp_word.ready;
   assign accept         = req_word.valid && req_word.ready;
   assign shift_en       = accept && !finished_ff;

   assign chain[0] = req_word.data_byte;

   for (genvar j = 0; j < LANES; j++) begin : g_cell
      mbps_cell #(.INDEX(j)) u_cell (
         .clock       (clock),
         .shift_en    (shift_en),
         .shift_byte  (chain[j]),
         .window_byte (chain[j+1]),
         .cfg         (cfg),
         .eff_len     (eff_len),
         .hit         (hits[j])
      );
   end

   assign pos_next   = (pos_ff == 32'hFFFF_FFFF) ? pos_ff : pos_ff + 32'd1;
   assign full_hit   = (&hits) && (eff_len != '0) && (pos_next >= 32'(eff_len));
   assign count_next = (full_hit && count_ff != 32'hFFFF_FFFF) ? count_ff + 32'd1 : count_ff;
   assign found      = full_hit && (count_next >= want);

   always_comb begin
      pos_in         = pos_ff;
      count_in       = count_ff;
      finished_in    = finished_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_word.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_address_in = rsp_address_ff;
      if (shift_en) begin
         pos_in      = pos_next;
         count_in    = count_next;
         finished_in = found;
         if (found) begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STATUS_FOUND;
            rsp_address_in = cfg.scan_base + pos_next - 32'(eff_len);
         end else if (req_word.last_byte) begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = (eff_len == '0) ? STATUS_EMPTY : STATUS_NOT_FOUND;
            rsp_address_in = '0;
         end
      end
      if (accept && req_word.last_byte) begin
         pos_in      = '0;
         count_in    = '0;
         finished_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         count_ff     <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_address_ff <= rsp_address_in;
   end

   assign rsp_word.valid         = rsp_valid_ff;
   assign rsp_word.status        = rsp_status_ff;
   assign rsp_word.match_address = rsp_address_ff;

`ifndef SYNTHESIS
   a_finished_has_count: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> count_ff != 32'd0)
      else $error("finished without a counted match");

   a_miss_has_no_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_FOUND) |-> rsp_address_ff == 32'd0)
      else $error("non-match result carries an address");

   a_last_clears_region: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.last_byte) |=> (pos_ff == 32'd0 && !finished_ff && count_ff == 32'd0))
      else $error("region state not cleared after last byte");
`endif

endmodule
